@@ rtl/msd_pkg.sv @@
// shared constants and types for the magic sync packet deframer
// no dependencies; imported by msd_core, msd_out and the top level
package msd_pkg;

  // header layout
  localparam int HEADER_BYTES = 36;
  localparam int MAGIC_OFFSET = 4;
  localparam int SIZE_OFFSET  = 16;

  // sync word after reset
  localparam logic [31:0] MAGIC_RESET = 32'hABCD4321;

  // hunting history and sync burst
  localparam int HIST_DEPTH = 7;
  localparam int BURST_MAX  = 8;
  localparam int SYNC_OFS   = (MAGIC_OFFSET > 4) ? 4 : MAGIC_OFFSET;
  localparam int SYNC_LEN   = SYNC_OFS + 4;

  // derived widths
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int POS_W  = $clog2(HEADER_BYTES);
  localparam int IDX_W  = $clog2(BURST_MAX);

  // one run of results caused by a single input byte
  typedef struct packed {
    logic                          load;
    logic                          burst;
    logic [BURST_MAX-1:0][7:0]     bytes;
    logic                          last;
  } msd_run_t;

endpackage

@@ rtl/msd_core.sv @@
// deframing state: sync hunt, header tracking, size capture, payload count
// depends on msd_pkg; loads one msd_run_t per processed byte, none for a hunted byte without a match
module msd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [31:0]     cfg_data,
  input  logic            step,
  input  logic [7:0]      step_byte,
  output msd_pkg::msd_run_t run
);
  import msd_pkg::*;

  localparam logic [POS_W:0] SIZE_LO = (POS_W + 1)'(SIZE_OFFSET);
  localparam logic [POS_W:0] SIZE_HI = (POS_W + 1)'(SIZE_OFFSET + 4);
  localparam logic [POS_W:0] HDR_LEN = (POS_W + 1)'(HEADER_BYTES);

  logic [31:0]                magic_word;
  logic [HIST_DEPTH-1:0][7:0] hist, hist_next;
  logic [FILL_W-1:0]          fill, fill_next;
  logic                       in_packet, in_packet_next;
  logic [POS_W-1:0]           hdr_pos, hdr_pos_next;
  logic [31:0]                payload_length, payload_length_next;
  logic [31:0]                bytes_remaining, bytes_remaining_next;

  logic [BURST_MAX-1:0][7:0]  win;
  logic                       match;
  logic [POS_W:0]             pos_ext;
  logic                       in_size;
  logic [1:0]                 lane;
  logic [31:0]                len_capt;

  // sync window: held bytes oldest first, new byte at the end
  for (genvar i = 0; i < BURST_MAX; i++) begin : g_win
    if (i < SYNC_LEN - 1) begin : g_held
      assign win[i] = hist[HIST_DEPTH + 1 - SYNC_LEN + i];
    end else if (i == SYNC_LEN - 1) begin : g_new
      assign win[i] = step_byte;
    end else begin : g_pad
      assign win[i] = 8'h00;
    end
  end

  assign match = (fill >= FILL_W'(SYNC_LEN - 1)) &&
                 ({win[SYNC_OFS+3], win[SYNC_OFS+2], win[SYNC_OFS+1], win[SYNC_OFS]}
                  == magic_word);

  // size field capture at the current header position
  assign pos_ext  = {1'b0, hdr_pos};
  assign in_size  = (pos_ext >= SIZE_LO) && (pos_ext < SIZE_HI) && (pos_ext < HDR_LEN);
  assign lane     = 2'(pos_ext - SIZE_LO);
  assign len_capt = in_size ? (payload_length | (32'(step_byte) << {lane, 3'b000}))
                            : payload_length;

  // next state and run for the byte being processed
  always_comb begin
    hist_next            = hist;
    fill_next            = fill;
    in_packet_next       = in_packet;
    hdr_pos_next         = hdr_pos;
    payload_length_next  = payload_length;
    bytes_remaining_next = bytes_remaining;
    run                  = '0;
    if (step) begin
      if (!in_packet) begin
        if (match) begin
          // burst positions lie below the size field, so nothing is captured
          in_packet_next       = 1'b1;
          payload_length_next  = '0;
          bytes_remaining_next = '0;
          fill_next            = '0;
          hdr_pos_next         = POS_W'(SYNC_LEN);
          run.load             = 1'b1;
          run.burst            = 1'b1;
          run.bytes            = win;
        end else begin
          hist_next = {step_byte, hist[HIST_DEPTH-1:1]};
          if (fill < FILL_W'(HIST_DEPTH)) begin
            fill_next = fill + 1'b1;
          end
        end
      end else if (bytes_remaining != '0) begin
        // payload byte
        bytes_remaining_next = bytes_remaining - 1'b1;
        run.load             = 1'b1;
        run.bytes[0]         = step_byte;
        if (bytes_remaining == 32'd1) begin
          run.last       = 1'b1;
          in_packet_next = 1'b0;
          hdr_pos_next   = '0;
          fill_next      = '0;
        end
      end else begin
        // header byte
        payload_length_next = len_capt;
        run.load            = 1'b1;
        run.bytes[0]        = step_byte;
        if (hdr_pos == POS_W'(HEADER_BYTES - 1)) begin
          hdr_pos_next = '0;
          if (len_capt == '0) begin
            run.last       = 1'b1;
            in_packet_next = 1'b0;
            fill_next      = '0;
          end else begin
            bytes_remaining_next = len_capt;
          end
        end else begin
          hdr_pos_next = hdr_pos + 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    hist <= hist_next;
    if (rst) begin
      magic_word      <= MAGIC_RESET;
      fill            <= '0;
      in_packet       <= 1'b0;
      hdr_pos         <= '0;
      payload_length  <= '0;
      bytes_remaining <= '0;
    end else begin
      if (cfg_write) begin
        magic_word <= cfg_data;
      end
      fill            <= fill_next;
      in_packet       <= in_packet_next;
      hdr_pos         <= hdr_pos_next;
      payload_length  <= payload_length_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_in_packet: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining != '0) |-> in_packet)
    else $error("payload count active while hunting");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(HIST_DEPTH))
    else $error("history fill out of range");

  a_match_enters: assert property (@(posedge clk) disable iff (rst)
    (step && !in_packet && match) |=> (in_packet && hdr_pos == POS_W'(SYNC_LEN)))
    else $error("sync match did not enter header");
`endif

endmodule

@@ rtl/msd_out.sv @@
// result register: holds one run and hands it out one result per transfer
// depends on msd_pkg; loaded from msd_core
module msd_out (
  input  logic              clk,
  input  logic              rst,
  input  msd_pkg::msd_run_t run,
  output logic              run_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_byte,
  output logic              first_of_packet,
  output logic              last_of_packet,
  output logic              end_of_run
);
  import msd_pkg::*;

  logic                      run_valid;
  logic                      run_burst;
  logic                      run_last;
  logic [BURST_MAX-1:0][7:0] run_bytes;
  logic [IDX_W-1:0]          run_idx;
  logic [IDX_W-1:0]          last_idx;
  logic                      at_end;
  logic                      xfer;

  // position of the final result in the held run
  assign last_idx = run_burst ? IDX_W'(SYNC_LEN - 1) : '0;
  assign at_end   = (run_idx == last_idx);
  assign xfer     = run_valid && !out_stall;
  assign run_free = !run_valid || (xfer && at_end);

  // result fields
  assign out_valid       = run_valid;
  assign data_byte       = run_bytes[run_idx];
  assign first_of_packet = run_burst && (run_idx == '0);
  assign last_of_packet  = run_last && at_end;
  assign end_of_run      = at_end;

  // run payload, no reset needed
  always_ff @(posedge clk) begin
    if (run.load) begin
      run_burst <= run.burst;
      run_last  <= run.last;
      run_bytes <= run.bytes;
    end
  end

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx   <= '0;
    end else if (run.load) begin
      run_valid <= 1'b1;
      run_idx   <= '0;
    end else if (xfer) begin
      if (at_end) begin
        run_valid <= 1'b0;
        run_idx   <= '0;
      end else begin
        run_idx <= run_idx + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (run_idx <= last_idx))
    else $error("result index past end of run");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    run.load |-> run_free)
    else $error("run loaded over pending results");
`endif

endmodule

@@ rtl/magic_sync_packet_deframer.sv @@
// magic sync packet deframer: input register, deframing core, result register
// path: an input byte that yields results reaches the outputs through the input register, then the result register
// throughput: 1 byte per cycle while out_stall is low; a sync match emits an 8-result
//   burst from the result register, during which the input register holds the next byte
// reset: synchronous active-high rst clears the pipeline, the deframer state
//   (hunting, empty history) and loads the default sync word
module magic_sync_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        first_of_packet,
  output logic        last_of_packet,
  output logic        end_of_run
);
  import msd_pkg::*;

  logic       in_r_valid;
  logic [7:0] in_r_byte;
  logic       run_free;
  logic       step;
  msd_run_t   run;

  // input register advances when the result register can take its run
  assign step     = in_r_valid && run_free;
  assign in_stall = in_r_valid && !run_free;

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r_byte <= in_byte;
    end
  end

  // input register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_r_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_r_valid <= 1'b1;
    end else if (step) begin
      in_r_valid <= 1'b0;
    end
  end

  // deframing state
  msd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (step),
    .step_byte (in_r_byte),
    .run       (run)
  );

  // result register
  msd_out u_out (
    .clk             (clk),
    .rst             (rst),
    .run             (run),
    .run_free        (run_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .end_of_run      (end_of_run)
  );

endmodule
